@@ rtl/tlfs_pkg.sv @@
// Types and constants for the three-level feedback scheduler.
// No dependencies.
package tlfs_pkg;
  localparam int unsigned MAX_JOBS_DEF   = 16;
  localparam int unsigned NUM_LEVELS_DEF = 3;
  localparam int unsigned JOB_W  = 4;
  localparam int unsigned EL_W   = 16;
  localparam int unsigned TICK_W = 32;
  localparam logic [EL_W-1:0] MAX_RUN_RESET = 16'd20;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_QUEUED   = 3'd1,
    EV_STARTED  = 3'd2,
    EV_RESUMED  = 3'd3,
    EV_DROPPED  = 3'd4,
    EV_PREEMPT  = 3'd5,
    EV_FINISHED = 3'd6,
    EV_KILLED   = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;
endpackage

@@ rtl/tlfs_if.sv @@
// Valid/ready channel interfaces for the scheduler.
// Depends on tlfs_pkg.
interface tlfs_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [tlfs_pkg::JOB_W-1:0] job_id;
  logic job_done;
  logic resume_ok;
  modport source (output valid, op, job_id, job_done, resume_ok, input ready);
  modport sink   (input valid, op, job_id, job_done, resume_ok, output ready);
endinterface

interface tlfs_out_if;
  logic valid;
  logic ready;
  logic [2:0] event_res;
  logic [tlfs_pkg::JOB_W-1:0] event_job;
  logic [tlfs_pkg::EL_W-1:0] elapsed_ticks;
  logic [tlfs_pkg::TICK_W-1:0] start_tick;
  logic [tlfs_pkg::TICK_W-1:0] now_tick;
  logic idle;
  modport source (output valid, event_res, event_job, elapsed_ticks, start_tick, now_tick,
                  idle, input ready);
  modport sink   (input valid, event_res, event_job, elapsed_ticks, start_tick, now_tick,
                  idle, output ready);
endinterface

@@ rtl/tlfs_job_mem.sv @@
// Per-job table memory: elapsed, start tick, level, started flag.
// Depends on tlfs_pkg. One write port, one read port, registered read.
module tlfs_job_mem #(
  parameter int unsigned MAX_JOBS = tlfs_pkg::MAX_JOBS_DEF,
  parameter int unsigned LVL_W    = 2,
  localparam int unsigned AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1,
  localparam int unsigned DW = tlfs_pkg::EL_W + tlfs_pkg::TICK_W + LVL_W + 1
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);
  logic [DW-1:0] mem [MAX_JOBS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

@@ rtl/tlfs_fifo_mem.sv @@
// Storage for all level FIFOs, one row per level and slot.
// Depends on tlfs_pkg. One write port, one read port, registered read.
module tlfs_fifo_mem #(
  parameter int unsigned DEPTH = 48,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic [AW-1:0]              rd_addr,
  output logic [tlfs_pkg::JOB_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [tlfs_pkg::JOB_W-1:0] wr_data
);
  logic [tlfs_pkg::JOB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

@@ rtl/three_level_feedback_scheduler.sv @@
// Top level of the multilevel feedback scheduler.
// Depends on tlfs_pkg, tlfs_if, tlfs_job_mem, tlfs_fifo_mem.
//
// Usage:
//  in  channel: op (0 arrival of job_id, 1 tick with job_done/resume_ok).
//  out channel: one result per input transfer (event, job, elapsed, start,
//               current tick, idle).
//  cfg: cfg_we/cfg_wdata write max_run_ticks (reset 20).
// Timing: the FIFO head and the running job's table entry are read at the
//  accepting edge; the EXEC state modifies, writes back and loads the
//  result register, and the result is valid in the OUT state that follows.
//  A tick that takes a job off a queue stays in EXEC once more to read that
//  job's table entry. A new item is accepted only in IDLE, after the result
//  transfer, so the block takes no new item while one is still in flight.
// Reset (rst_n low, synchronous) empties all queues, clears the running
//  job and tick counter and sets the limit to 20; the per-job table is
//  undefined until an arrival writes the entry. No clearing pass is needed.
// When the receiver stalls, the result is held and no input is accepted.
module three_level_feedback_scheduler #(
  parameter int unsigned MAX_JOBS   = tlfs_pkg::MAX_JOBS_DEF,
  parameter int unsigned NUM_LEVELS = tlfs_pkg::NUM_LEVELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  tlfs_in_if.sink                   in_ch,
  tlfs_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [tlfs_pkg::EL_W-1:0] cfg_wdata
);
  localparam int unsigned JW    = tlfs_pkg::JOB_W;
  localparam int unsigned EW    = tlfs_pkg::EL_W;
  localparam int unsigned TW    = tlfs_pkg::TICK_W;
  localparam int unsigned SW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW    = $clog2(MAX_JOBS + 1);
  localparam int unsigned LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned FD    = NUM_LEVELS * MAX_JOBS;
  localparam int unsigned FAW   = (FD > 1) ? $clog2(FD) : 1;
  localparam int unsigned DW    = EW + TW + LW + 1;
  localparam logic [LW-1:0] TOP = LW'(NUM_LEVELS - 1);

  tlfs_pkg::state_t state_r, state_nxt;
  logic [EW-1:0] max_r;
  logic [SW-1:0] head_r [NUM_LEVELS];
  logic [CW-1:0] cnt_r  [NUM_LEVELS];
  logic [JW-1:0] run_job_r;
  logic          run_r;
  logic [TW-1:0] tick_r;

  logic          op_r, done_r, rok_r;
  logic [JW-1:0] jid_r;
  logic [LW-1:0] hl_r;   // highest non-empty level at accept
  logic          any_r;

  logic [2:0]    o_ev_r;
  logic [JW-1:0] o_job_r;
  logic [EW-1:0] o_el_r;
  logic [TW-1:0] o_st_r;
  logic          o_idle_r;

  // highest non-empty level
  logic [LW-1:0] hl;
  logic          any_w;
  always_comb begin
    hl    = '0;
    any_w = 1'b0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (cnt_r[l] != '0) begin
        hl    = LW'(l);
        any_w = 1'b1;
      end
    end
  end

  function automatic logic [FAW-1:0] faddr(input logic [LW-1:0] lvl, input logic [SW-1:0] sl);
    faddr = FAW'(FAW'(lvl) * FAW'(MAX_JOBS) + FAW'(sl));
  endfunction

  // head + count stays below twice the depth
  function automatic logic [SW-1:0] wrap(input logic [CW:0] v);
    wrap = (v >= (CW+1)'(MAX_JOBS)) ? SW'(v - (CW+1)'(MAX_JOBS)) : SW'(v);
  endfunction

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == tlfs_pkg::ST_IDLE);

  // memory ports
  logic [SW-1:0] jrd_addr, jwr_addr, jrd_sel;
  logic [DW-1:0] jrd_data, jwr_data;
  logic          jwr_en;
  logic [FAW-1:0] frd_addr, fwr_addr;
  logic [JW-1:0] frd_data, fwr_data;
  logic          fwr_en;

  assign jrd_addr = SW'(run_job_r);
  assign frd_addr = faddr(hl, head_r[hl]);

  tlfs_job_mem #(.MAX_JOBS(MAX_JOBS), .LVL_W(LW)) u_job (
    .clk, .rd_addr(jrd_sel), .rd_data(jrd_data),
    .wr_en(jwr_en), .wr_addr(jwr_addr), .wr_data(jwr_data)
  );
  tlfs_fifo_mem #(.DEPTH(FD)) u_fifo (
    .clk, .rd_addr(frd_addr), .rd_data(frd_data),
    .wr_en(fwr_en), .wr_addr(fwr_addr), .wr_data(fwr_data)
  );

  // second read of job table for the popped head: job table read uses
  // running job; for the idle path the head id arrives in EXEC and the
  // table is read again in a second pass through EXEC.
  logic          hd_rd_r;      // second-pass read of popped head entry
  logic [JW-1:0] hd_job_r;
  logic [SW-1:0] jrd2;
  assign jrd2 = SW'(frd_data);

  // decode job entry
  logic [EW-1:0] e_el;
  logic [TW-1:0] e_st;
  logic [LW-1:0] e_lv;
  logic          e_sf;
  assign {e_el, e_st, e_lv, e_sf} = jrd_data;

  logic [SW-1:0] head_nxt [NUM_LEVELS];
  logic [CW-1:0] cnt_nxt  [NUM_LEVELS];
  logic [JW-1:0] run_job_nxt;
  logic          run_nxt;
  logic [TW-1:0] tick_nxt;
  logic [2:0]    ev;
  logic [JW-1:0] ej;
  logic [EW-1:0] el, el_inc;
  logic [TW-1:0] st;
  logic [LW-1:0] nl;
  logic          hd_rd_nxt;
  logic          any_after;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    run_job_nxt = run_job_r;
    run_nxt     = run_r;
    tick_nxt    = tick_r;
    hd_rd_nxt   = 1'b0;
    jwr_en      = 1'b0;
    jwr_addr    = SW'(run_job_r);
    jwr_data    = jrd_data;
    fwr_en      = 1'b0;
    fwr_addr    = faddr(TOP, wrap((CW+1)'(head_r[TOP]) + (CW+1)'(cnt_r[TOP])));
    fwr_data    = jid_r;
    ev = tlfs_pkg::EV_NONE;
    ej = '0;
    el = '0;
    st = '0;
    el_inc = (e_el != '1) ? e_el + EW'(1) : e_el;
    nl = (e_lv > '0) ? e_lv - LW'(1) : '0;
    if (nl > TOP) nl = TOP;
    unique case (state_r)
      tlfs_pkg::ST_IDLE: begin
        if (accept) state_nxt = tlfs_pkg::ST_EXEC;
      end
      tlfs_pkg::ST_EXEC: begin
        state_nxt = tlfs_pkg::ST_OUT;
        if (op_r == tlfs_pkg::OP_ARRIVAL) begin
          if (cnt_r[TOP] < CW'(MAX_JOBS)) begin
            fwr_en = 1'b1;
            cnt_nxt[TOP] = cnt_r[TOP] + CW'(1);
            jwr_en   = 1'b1;
            jwr_addr = SW'(jid_r);
            jwr_data = {EW'(0), TW'(0), TOP, 1'b0};
            ev = tlfs_pkg::EV_QUEUED;
            ej = jid_r;
          end
        end else if (run_r) begin
          jwr_en = 1'b1;
          jwr_data = {el_inc, e_st, e_lv, e_sf};
          if (el_inc >= max_r) begin
            ev = tlfs_pkg::EV_KILLED;
          end else if (done_r) begin
            ev = tlfs_pkg::EV_FINISHED;
          end else if (any_r) begin
            ev = tlfs_pkg::EV_PREEMPT;
            jwr_data = {el_inc, e_st, nl, e_sf};
            if (cnt_r[nl] < CW'(MAX_JOBS)) begin
              fwr_en   = 1'b1;
              fwr_addr = faddr(nl, wrap((CW+1)'(head_r[nl]) + (CW+1)'(cnt_r[nl])));
              fwr_data = run_job_r;
              cnt_nxt[nl] = cnt_r[nl] + CW'(1);
            end
          end
          if (ev != tlfs_pkg::EV_NONE) begin
            run_nxt = 1'b0;
            ej = run_job_r;
            el = el_inc;
            st = e_sf ? e_st : '0;
          end
          tick_nxt = tick_r + TW'(1);
        end else if (any_r) begin
          // pop head; entry read needs a second pass through EXEC
          head_nxt[hl_r] = wrap((CW+1)'(head_r[hl_r]) + (CW+1)'(1));
          cnt_nxt[hl_r]  = cnt_r[hl_r] - CW'(1);
          run_job_nxt    = frd_data;
          hd_rd_nxt      = 1'b1;
          state_nxt      = tlfs_pkg::ST_EXEC;
          if (hd_rd_r) begin
            head_nxt    = head_r;
            cnt_nxt     = cnt_r;
            run_job_nxt = hd_job_r;
            hd_rd_nxt   = 1'b0;
            state_nxt   = tlfs_pkg::ST_OUT;
            ej = hd_job_r;
            el = e_el;
            jwr_addr = SW'(hd_job_r);
            if (e_sf) begin
              st = e_st;
              if (rok_r) begin
                ev = tlfs_pkg::EV_RESUMED;
                run_nxt = 1'b1;
              end else begin
                ev = tlfs_pkg::EV_DROPPED;
                run_job_nxt = run_job_r;
              end
            end else begin
              ev = tlfs_pkg::EV_STARTED;
              st = tick_r;
              run_nxt = 1'b1;
              jwr_en = 1'b1;
              jwr_data = {e_el, tick_r, e_lv, 1'b1};
            end
            tick_nxt = tick_r + TW'(1);
          end
        end else begin
          tick_nxt = tick_r + TW'(1);
        end
      end
      tlfs_pkg::ST_OUT: begin
        if (out_ch.ready) state_nxt = tlfs_pkg::ST_IDLE;
      end
      default: state_nxt = tlfs_pkg::ST_IDLE;
    endcase
    any_after = 1'b0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (cnt_nxt[l] != '0) any_after = 1'b1;
    end
  end

  // during the head pass the table must be read at the popped id
  assign jrd_sel = hd_rd_nxt ? jrd2 : jrd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tlfs_pkg::ST_IDLE;
      max_r     <= tlfs_pkg::MAX_RUN_RESET;
      run_job_r <= '0;
      run_r     <= 1'b0;
      tick_r    <= '0;
      hd_rd_r   <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      run_r     <= run_nxt;
      tick_r    <= tick_nxt;
      hd_rd_r   <= hd_rd_nxt;
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      run_job_r <= hd_rd_nxt ? run_job_r : run_job_nxt;
      if (cfg_we) max_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_ch.op;
      jid_r  <= in_ch.job_id;
      done_r <= in_ch.job_done;
      rok_r  <= in_ch.resume_ok;
      hl_r   <= hl;
      any_r  <= any_w;
    end
    if (hd_rd_nxt) hd_job_r <= frd_data;
    if (state_r == tlfs_pkg::ST_EXEC && state_nxt == tlfs_pkg::ST_OUT) begin
      o_ev_r   <= ev;
      o_job_r  <= ej;
      o_el_r   <= el;
      o_st_r   <= st;
      o_idle_r <= !run_nxt && !any_after;
    end
  end

  assign out_ch.valid         = (state_r == tlfs_pkg::ST_OUT);
  assign out_ch.event_res     = o_ev_r;
  assign out_ch.event_job     = o_job_r;
  assign out_ch.elapsed_ticks = o_el_r;
  assign out_ch.start_tick    = o_st_r;
  assign out_ch.now_tick      = tick_r;
  assign out_ch.idle          = o_idle_r;

  a_one_hot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({state_r == tlfs_pkg::ST_IDLE, state_r == tlfs_pkg::ST_EXEC,
             state_r == tlfs_pkg::ST_OUT}))
    else $error("state code invalid");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while result pending");
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tlfs_pkg::ST_IDLE) |=> $stable(tick_r) || !rst_n)
    else $error("tick moved while idle");
endmodule
